// ===== sv/bdm_pkg.sv =====
// Shared types, constants and helper functions for the bracket deque matcher.
// No dependencies; every other file refers to it by scoped names.
package bdm_pkg;

   localparam int DEPTH    = 1024;
   localparam int LEN_BITS = 32;
   localparam int OUT_BITS = 32;
   localparam int IDX_W    = $clog2(DEPTH);
   localparam int GAP_W    = $clog2(DEPTH + 1);
   localparam int CNT_W    = $clog2(DEPTH + 1);

   localparam logic OP_FRONT = 1'b0;
   localparam logic OP_BACK  = 1'b1;

   localparam logic [7:0] SYM_LPAREN  = 8'h28;
   localparam logic [7:0] SYM_RPAREN  = 8'h29;
   localparam logic [7:0] SYM_LSQUARE = 8'h5B;
   localparam logic [7:0] SYM_RSQUARE = 8'h5D;

   localparam logic [LEN_BITS-1:0] PAIR_LEN = LEN_BITS'(2);

   typedef struct packed {
      logic       op;
      logic [7:0] symbol;
   } req_type;

   typedef struct packed {
      logic [OUT_BITS-1:0] run_length;
      logic                overflow;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic look;
      logic commit;
   } cmd_type;

   // True if opener o and closer c form a pair.
   function automatic logic is_pair(input logic [7:0] o, input logic [7:0] c);
      return ((o == SYM_LPAREN) && (c == SYM_RPAREN)) ||
             ((o == SYM_LSQUARE) && (c == SYM_RSQUARE));
   endfunction

   function automatic logic [LEN_BITS-1:0] sat_add(input logic [LEN_BITS-1:0] a,
                                                   input logic [LEN_BITS-1:0] b);
      logic [LEN_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[LEN_BITS] ? {LEN_BITS{1'b1}} : s[LEN_BITS-1:0];
   endfunction

endpackage

// ===== sv/bdm_ctrl.sv =====
// Sequencing controller of the bracket deque matcher.
// Uses bdm_pkg for the command struct; drives the datapath by commands only.
module bdm_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bdm_pkg::cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOK,
      ST_COMMIT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      commit;

   assign req_ready = (state_ff == ST_IDLE);
   assign commit    = (state_ff == ST_COMMIT) && (!rsp_valid_ff || rsp_ready);

   assign cmd.capture = req_valid && req_ready;
   assign cmd.look    = (state_ff == ST_LOOK);
   assign cmd.commit  = commit;
   assign rsp_valid   = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // hold the result until taken; a fresh one only loads once the slot is free
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== sv/bdm_datapath.sv =====
// Datapath of the bracket deque matcher: character ring, gap ring, pointers, result register.
// Uses bdm_pkg for types, sizes and the pairing and saturating-add functions.
module bdm_datapath (
   input  logic             clock,
   input  logic             reset,
   input  bdm_pkg::cmd_type cmd,
   input  bdm_pkg::req_type req_data,
   output bdm_pkg::rsp_type rsp_data
);

   logic [7:0]                   char_mem [bdm_pkg::DEPTH];
   logic [bdm_pkg::LEN_BITS-1:0] gap_mem  [bdm_pkg::DEPTH + 1];

   logic [bdm_pkg::IDX_W-1:0] front_ff, back_ff;
   logic [bdm_pkg::GAP_W-1:0] gap_front_ff, gap_back_ff;
   logic [bdm_pkg::CNT_W-1:0] count_ff;
   logic                      gap0_set_ff;

   logic                         op_ff;
   logic [7:0]                   sym_ff;
   logic [7:0]                   char_q_ff;
   logic [bdm_pkg::LEN_BITS-1:0] gap_end_q_ff, gap_inner_q_ff;
   logic                         end_zero_ff, inner_zero_ff;
   logic [bdm_pkg::GAP_W-1:0]    inner_addr_ff;
   logic                         match_ff, ovf_ff;
   logic [bdm_pkg::LEN_BITS-1:0] run_ff, inner_val_ff;
   bdm_pkg::rsp_type             rsp_ff;

   logic [bdm_pkg::IDX_W-1:0]    char_rd_addr;
   logic [bdm_pkg::GAP_W-1:0]    end_addr, inner_addr;
   logic [bdm_pkg::LEN_BITS-1:0] gap_end, gap_inner;
   logic                         full;
   logic                         match_in, ovf_in;
   logic [bdm_pkg::LEN_BITS-1:0] run_in, sum;
   logic                         gap_wr_en, char_wr_en;
   logic [bdm_pkg::GAP_W-1:0]    gap_wr_addr;
   logic [bdm_pkg::LEN_BITS-1:0] gap_wr_data;
   logic [bdm_pkg::IDX_W-1:0]    char_wr_addr;
   logic [63:0]                  run_wide;

   function automatic logic [bdm_pkg::IDX_W-1:0] idx_inc(input logic [bdm_pkg::IDX_W-1:0] x);
      return (x == bdm_pkg::IDX_W'(bdm_pkg::DEPTH - 1)) ? '0 : x + 1'b1;
   endfunction

   function automatic logic [bdm_pkg::IDX_W-1:0] idx_dec(input logic [bdm_pkg::IDX_W-1:0] x);
      return (x == '0) ? bdm_pkg::IDX_W'(bdm_pkg::DEPTH - 1) : x - 1'b1;
   endfunction

   function automatic logic [bdm_pkg::GAP_W-1:0] gap_inc(input logic [bdm_pkg::GAP_W-1:0] x);
      return (x == bdm_pkg::GAP_W'(bdm_pkg::DEPTH)) ? '0 : x + 1'b1;
   endfunction

   function automatic logic [bdm_pkg::GAP_W-1:0] gap_dec(input logic [bdm_pkg::GAP_W-1:0] x);
      return (x == '0) ? bdm_pkg::GAP_W'(bdm_pkg::DEPTH) : x - 1'b1;
   endfunction

   // read addresses: the end character, the end gap and the gap just inside it
   always_comb begin
      if (req_data.op == bdm_pkg::OP_BACK) begin
         char_rd_addr = back_ff;
         end_addr     = gap_back_ff;
         inner_addr   = gap_dec(gap_back_ff);
      end else begin
         char_rd_addr = front_ff;
         end_addr     = gap_front_ff;
         inner_addr   = gap_inc(gap_front_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         char_q_ff      <= char_mem[char_rd_addr];
         gap_end_q_ff   <= gap_mem[end_addr];
         gap_inner_q_ff <= gap_mem[inner_addr];
         end_zero_ff    <= (end_addr == '0) && !gap0_set_ff;
         inner_zero_ff  <= (inner_addr == '0) && !gap0_set_ff;
         inner_addr_ff  <= inner_addr;
         op_ff          <= req_data.op;
         sym_ff         <= req_data.symbol;
      end
   end

   // gap entry zero reads as zero until first written
   assign gap_end   = end_zero_ff ? '0 : gap_end_q_ff;
   assign gap_inner = inner_zero_ff ? '0 : gap_inner_q_ff;
   assign full      = (count_ff == bdm_pkg::CNT_W'(bdm_pkg::DEPTH));

   always_comb begin
      if (op_ff == bdm_pkg::OP_BACK) begin
         match_in = (count_ff != '0) && bdm_pkg::is_pair(char_q_ff, sym_ff);
      end else begin
         match_in = (count_ff != '0) && bdm_pkg::is_pair(sym_ff, char_q_ff);
      end
      run_in = match_in ? bdm_pkg::sat_add(gap_end, bdm_pkg::PAIR_LEN) : '0;
      ovf_in = !match_in && full;
   end

   always_ff @(posedge clock) begin
      if (cmd.look) begin
         match_ff     <= match_in;
         ovf_ff       <= ovf_in;
         run_ff       <= run_in;
         inner_val_ff <= gap_inner;
      end
   end

   assign sum = bdm_pkg::sat_add(inner_val_ff, run_ff);

   // write-back: merge into the inner gap on a match, else store and open a zero gap unless full
   always_comb begin
      gap_wr_en    = 1'b0;
      char_wr_en   = 1'b0;
      gap_wr_addr  = inner_addr_ff;
      gap_wr_data  = sum;
      char_wr_addr = (op_ff == bdm_pkg::OP_BACK) ? idx_inc(back_ff) : idx_dec(front_ff);
      if (cmd.commit) begin
         if (match_ff) begin
            gap_wr_en = 1'b1;
         end else if (!full) begin
            gap_wr_en   = 1'b1;
            char_wr_en  = 1'b1;
            gap_wr_data = '0;
            gap_wr_addr = (op_ff == bdm_pkg::OP_BACK) ? gap_inc(gap_back_ff)
                                                      : gap_dec(gap_front_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (gap_wr_en) begin
         gap_mem[gap_wr_addr] <= gap_wr_data;
      end
      if (char_wr_en) begin
         char_mem[char_wr_addr] <= sym_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= bdm_pkg::IDX_W'(bdm_pkg::DEPTH / 2);
         back_ff      <= bdm_pkg::IDX_W'(bdm_pkg::DEPTH / 2 - 1);
         gap_front_ff <= '0;
         gap_back_ff  <= '0;
         count_ff     <= '0;
         gap0_set_ff  <= 1'b0;
      end else begin
         if (gap_wr_en && (gap_wr_addr == '0)) begin
            gap0_set_ff <= 1'b1;
         end
         if (cmd.commit) begin
            if (match_ff) begin
               count_ff <= count_ff - 1'b1;
               if (op_ff == bdm_pkg::OP_BACK) begin
                  back_ff     <= idx_dec(back_ff);
                  gap_back_ff <= gap_dec(gap_back_ff);
               end else begin
                  front_ff     <= idx_inc(front_ff);
                  gap_front_ff <= gap_inc(gap_front_ff);
               end
            end else if (!full) begin
               count_ff <= count_ff + 1'b1;
               if (op_ff == bdm_pkg::OP_BACK) begin
                  back_ff     <= idx_inc(back_ff);
                  gap_back_ff <= gap_inc(gap_back_ff);
               end else begin
                  front_ff     <= idx_dec(front_ff);
                  gap_front_ff <= gap_dec(gap_front_ff);
               end
            end
         end
      end
   end

   assign run_wide = 64'(run_ff);

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff.run_length <= (|run_wide[63:bdm_pkg::OUT_BITS]) ? {bdm_pkg::OUT_BITS{1'b1}}
                                                              : run_wide[bdm_pkg::OUT_BITS-1:0];
         rsp_ff.overflow   <= ovf_ff;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== sv/bracket_deque_matcher.sv =====
// Top level of the bracket deque matcher: controller plus datapath.
// Depends on bdm_pkg, bdm_ctrl and bdm_datapath.
//
// Each request pushes one character at the front (op 0) or back (op 1) of a
// deque of unmatched characters, kept in a ring of bdm_pkg::DEPTH bytes. The
// lengths of the regular bracket runs around and between the stored characters
// sit in a second ring of DEPTH+1 gap entries. A closing bracket at the back that
// pairs with the stored back character, or an opening bracket at the front that
// pairs with a stored closing front character, removes that character; the
// response then carries the end gap length plus two, and that amount is added
// into the gap that becomes the new end gap. Any other character is stored with
// a new zero gap and the response carries zero. A push that cannot match into a
// full store is dropped and flagged with overflow. All lengths saturate.
// Timing: each request is captured, looked at and committed in turn - the
// accepting edge does the registered read of the end character, the end gap and
// the gap inside it, the look step tests the pair and forms the run, the commit
// step writes back, updates the pointers and loads the response. The controller
// then returns to idle, where it takes the next request; one request is in flight
// at a time, so a new request is not taken until the previous one is committed;
// a new request is accepted while the previous response still waits, and only
// the write-back stalls on a full response slot. No clearing pass is needed after
// reset: the single initial gap is read as zero until first written.
module bracket_deque_matcher (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bdm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bdm_pkg::rsp_type rsp_data
);

   bdm_pkg::cmd_type cmd;

   // sequence each request: capture and read, look, commit
   bdm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // hold the rings, pointers and response register
   bdm_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule
